// ----- sv/crcfr_pkg.sv -----
`default_nettype none

package crcfr_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int HDR_BYTES   = 9;
  localparam int OVERHEAD    = 13;
  localparam int SYNC_BYTES  = 4;
  localparam int STORE_DEPTH = MAX_PAYLOAD + OVERHEAD;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int IDX_W       = $clog2(MAX_PAYLOAD);

  localparam int POS_SRC    = 4;
  localparam int POS_DST    = 5;
  localparam int POS_DATA   = 6;
  localparam int POS_LEN_LO = 7;
  localparam int POS_LEN_HI = 8;

  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [31:0] CRC_ALL_ONES = 32'hFFFFFFFF;

  localparam logic [1:0] CFG_SYNC_WORD = 2'd0;
  localparam logic [1:0] CFG_DEVICE_ID = 2'd1;
  localparam logic [1:0] CFG_FILTER_EN = 2'd2;

  localparam logic [3:0] PROG_NONE = 4'b0000;
  localparam logic [3:0] PROG_ONE  = 4'b0001;
  localparam logic [3:0] PROG_TWO  = 4'b0010;
  localparam logic [3:0] PROG_THREE = 4'b0100;
  localparam logic [3:0] PROG_FULL = 4'b1000;

  typedef enum logic [1:0] {
    RX_IDLE,
    RX_SYNC,
    RX_DRAIN
  } rx_state_t;

  typedef enum logic [1:0] {
    RD_IDLE,
    RD_FETCH,
    RD_LOAD
  } rd_state_t;

  typedef struct packed {
    logic [31:0] sync_word;
    logic [7:0]  device_id;
    logic        filter_enable;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [7:0]       source_id;
    logic [7:0]       dest_id;
    logic [7:0]       data_id;
    logic [LEN_W-1:0] length;
  } frame_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    int k;
    c = crc_in ^ {24'd0, b};
    for (k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/crcfr_store.sv -----
`default_nettype none

module crcfr_store import crcfr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [7:0]        wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [7:0]        rdata
);

  logic [7:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/crcfr_rx.sv -----
`default_nettype none

module crcfr_rx import crcfr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        rx_byte,
  output logic                   mem_we,
  output logic      [ADDR_W-1:0] mem_waddr,
  output logic      [7:0]        mem_wdata,
  output frame_t                 frame,
  input  wire logic              rd_done
);

  rx_state_t        state, state_next;
  logic [3:0]       progress, progress_next;
  logic             collecting;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_inc;
  logic [1:0]       sync_cnt;
  logic [31:0]      hist [4];
  logic [7:0]       tail [3];
  logic [7:0]       src, dst, did, len_lo, len_hi;

  logic        accept, match, stored, overflow;
  logic        len_hit, crc_hit, frame_ok, addr_ok;
  logic [31:0] crc_new, crc_sync, crc_want;
  logic [7:0]  sync_sel;

  assign accept    = in_valid && in_ready;
  assign count_inc = count + CNT_W'(1);
  assign stored    = accept && !match && collecting && (count != CNT_W'(STORE_DEPTH));
  assign overflow  = accept && !match && collecting && (count == CNT_W'(STORE_DEPTH));
  assign crc_new   = crc_byte(hist[0], rx_byte);
  assign sync_sel  = cfg.sync_word[8*sync_cnt +: 8];
  assign crc_sync  = crc_byte(hist[0], sync_sel);
  assign crc_want  = ~hist[3];
  assign len_hit   = (count_inc >= CNT_W'(OVERHEAD)) && (len_hi == 8'd0) &&
                     (len_lo == 8'(count_inc - CNT_W'(OVERHEAD)));
  assign crc_hit   = ({rx_byte, tail[0], tail[1], tail[2]} == crc_want);
  assign frame_ok  = stored && len_hit && crc_hit;
  assign addr_ok   = !cfg.filter_enable || (dst == cfg.device_id);

  always_comb begin
    match         = 1'b0;
    progress_next = PROG_NONE;
    priority if (rx_byte == cfg.sync_word[31:24] && progress == PROG_THREE) begin
      match         = 1'b1;
      progress_next = PROG_FULL;
    end else if (rx_byte == cfg.sync_word[23:16] && progress == PROG_TWO) begin
      progress_next = PROG_THREE;
    end else if (rx_byte == cfg.sync_word[15:8] && progress == PROG_ONE) begin
      progress_next = PROG_TWO;
    end else if (rx_byte == cfg.sync_word[7:0]) begin
      progress_next = PROG_ONE;
    end else begin
      progress_next = PROG_NONE;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      RX_IDLE: begin
        if (accept && match) begin
          state_next = RX_SYNC;
        end else if (frame_ok && addr_ok) begin
          state_next = RX_DRAIN;
        end
      end
      RX_SYNC: begin
        if (sync_cnt == 2'd3) begin
          state_next = RX_IDLE;
        end
      end
      RX_DRAIN: begin
        if (rd_done) begin
          state_next = RX_IDLE;
        end
      end
      default: state_next = RX_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = (state == RX_IDLE);
    mem_we          = stored;
    mem_waddr       = count[ADDR_W-1:0];
    mem_wdata       = rx_byte;
    frame.start     = frame_ok && addr_ok;
    frame.source_id = src;
    frame.dest_id   = dst;
    frame.data_id   = did;
    frame.length    = len_lo[LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= RX_IDLE;
      progress   <= PROG_NONE;
      collecting <= 1'b0;
      count      <= '0;
      sync_cnt   <= '0;
      for (int i = 0; i < 4; i++) begin
        hist[i] <= CRC_ALL_ONES;
      end
    end else begin
      state <= state_next;
      if (accept) begin
        progress <= progress_next;
      end
      if (accept && match) begin
        collecting <= 1'b1;
        count      <= CNT_W'(SYNC_BYTES);
        sync_cnt   <= '0;
        for (int i = 0; i < 4; i++) begin
          hist[i] <= CRC_ALL_ONES;
        end
      end else if (overflow) begin
        collecting <= 1'b0;
        count      <= '0;
      end else if (stored) begin
        count   <= count_inc;
        hist[0] <= crc_new;
        hist[1] <= hist[0];
        hist[2] <= hist[1];
        hist[3] <= hist[2];
        if (frame_ok) begin
          collecting <= 1'b0;
        end
      end else if (state == RX_SYNC) begin
        hist[0]  <= crc_sync;
        hist[1]  <= hist[0];
        hist[2]  <= hist[1];
        hist[3]  <= hist[2];
        sync_cnt <= sync_cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stored) begin
      tail[0] <= rx_byte;
      tail[1] <= tail[0];
      tail[2] <= tail[1];
      if (count == CNT_W'(POS_SRC)) begin
        src <= rx_byte;
      end
      if (count == CNT_W'(POS_DST)) begin
        dst <= rx_byte;
      end
      if (count == CNT_W'(POS_DATA)) begin
        did <= rx_byte;
      end
      if (count == CNT_W'(POS_LEN_LO)) begin
        len_lo <= rx_byte;
      end
      if (count == CNT_W'(POS_LEN_HI)) begin
        len_hi <= rx_byte;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/crcfr_read.sv -----
`default_nettype none

module crcfr_read import crcfr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire frame_t            frame,
  output logic                   mem_re,
  output logic      [ADDR_W-1:0] mem_raddr,
  input  wire logic [7:0]        mem_rdata,
  output logic                   rd_done,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [7:0]        source_id,
  output logic      [7:0]        dest_id,
  output logic      [7:0]        data_id,
  output logic      [LEN_W-1:0]  payload_length,
  output logic      [7:0]        payload_byte,
  output logic                   payload_valid,
  output logic                   last
);

  rd_state_t        state, state_next;
  logic [IDX_W-1:0] idx;
  logic [LEN_W-1:0] idx_inc;
  logic             empty, last_item, can_load, load;

  assign empty     = (frame.length == '0);
  assign idx_inc   = LEN_W'(idx) + LEN_W'(1);
  assign last_item = empty || (idx_inc == frame.length);
  assign can_load  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      RD_IDLE: begin
        if (frame.start) begin
          state_next = RD_FETCH;
        end
      end
      RD_FETCH: state_next = RD_LOAD;
      RD_LOAD: begin
        if (can_load) begin
          state_next = last_item ? RD_IDLE : RD_FETCH;
        end
      end
      default: state_next = RD_IDLE;
    endcase
  end

  always_comb begin
    mem_re    = (state == RD_FETCH) && !empty;
    mem_raddr = ADDR_W'(HDR_BYTES) + ADDR_W'(idx);
    load      = (state == RD_LOAD) && can_load;
    rd_done   = load && last_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= RD_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == RD_IDLE && frame.start) begin
        idx <= '0;
      end else if (load && !last_item) begin
        idx <= idx + IDX_W'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      source_id      <= frame.source_id;
      dest_id        <= frame.dest_id;
      data_id        <= frame.data_id;
      payload_length <= frame.length;
      payload_byte   <= empty ? 8'd0 : mem_rdata;
      payload_valid  <= !empty;
      last           <= last_item;
    end
  end

endmodule

`default_nettype wire

// ----- sv/crc32_frame_receiver.sv -----
// Sync word / length / CRC-32 frame receiver.
// Input channel: one received byte per transaction on rx_byte (in_valid, in_ready).
// A four-byte sync detector runs on every byte; a match restarts frame collection.
// Frame: sync, source id, destination id, data id, 16-bit LE length, payload,
// LE CRC-32 (reflected 0xEDB88320, init and final inversion) over all bytes before it.
// Output channel: one transaction per payload byte with the header fields
// (out_valid, out_ready); an empty payload gives one transaction with payload_valid 0.
// Configuration: cfg_we, cfg_index (0 sync word, 1 device id, 2 filter enable), cfg_data.
// Timing: a byte is taken whenever in_valid and in_ready are both high. After a sync match
// the input holds off while the CRC unit runs over the four sync bytes, one byte per cycle.
// After the CRC byte that completes a good frame that passes the address filter,
// each payload byte takes one frame store read followed by one output load.
// Input holds off during readout and reopens once the last result is loaded.
// A stalled receiver holds the output register and pauses the readout.
// Reset clears configuration, sync progress, byte count and control; frame store
// contents are not cleared and need no clearing pass.
`default_nettype none

module crc32_frame_receiver import crcfr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        rx_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [7:0]        source_id,
  output logic      [7:0]        dest_id,
  output logic      [7:0]        data_id,
  output logic      [LEN_W-1:0]  payload_length,
  output logic      [7:0]        payload_byte,
  output logic                   payload_valid,
  output logic                   last
);

  cfg_t              cfg;
  frame_t            frame;
  logic              mem_we, mem_re, rd_done;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_WORD: cfg.sync_word     <= cfg_data;
        CFG_DEVICE_ID: cfg.device_id     <= cfg_data[7:0];
        CFG_FILTER_EN: cfg.filter_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  crcfr_rx u_rx (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .frame     (frame),
    .rd_done   (rd_done)
  );

  crcfr_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  crcfr_read u_read (
    .clk            (clk),
    .rst            (rst),
    .frame          (frame),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata),
    .rd_done        (rd_done),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .source_id      (source_id),
    .dest_id        (dest_id),
    .data_id        (data_id),
    .payload_length (payload_length),
    .payload_byte   (payload_byte),
    .payload_valid  (payload_valid),
    .last           (last)
  );

endmodule

`default_nettype wire

// ----- sv/crcfr_checker.sv -----
`default_nettype none

module crcfr_checker import crcfr_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [7:0]       payload_byte,
  input wire logic [LEN_W-1:0] payload_length,
  input wire logic             payload_valid,
  input wire logic             last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte) && $stable(last))
    else $error("output transaction changed while stalled");

  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !payload_valid |-> last && payload_byte == 8'd0 && payload_length == '0)
    else $error("empty payload transaction malformed");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && payload_valid |-> payload_length != '0 &&
      payload_length <= LEN_W'(MAX_PAYLOAD))
    else $error("payload length out of range");

  a_in_during_readout: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input open before frame readout finished");

endmodule

bind crc32_frame_receiver crcfr_checker u_checker (.*);

`default_nettype wire
